/* sv/quadrature_encoder_velocity_defines.svh */
// ----------------------------------------------------------------------------
// Quadrature encoder velocity: assertion macros
// Shared concurrent assertion helpers, clocked on aclk and held off while
// aresetn is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_VELOCITY_DEFINES_SVH
`define QUADRATURE_ENCODER_VELOCITY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QEV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QEV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/qev_pkg.sv */
// ----------------------------------------------------------------------------
// Quadrature encoder velocity: shared package
// Widths, codes, register map and helper functions used across the block.
// ----------------------------------------------------------------------------
package qev_pkg;

    // Operand width of the shared multiplier.
    localparam int MUL_W = 32;

    // Divider: denominator is edges per rotation times the period.
    localparam int DEN_W = 40;
    localparam int QUO_W = 64;

    // Working accumulator: a 32 by 64 bit product.
    localparam int ACC_W = 96;

    // Microseconds per second and its width.
    localparam int               US_W          = 20;
    localparam logic [US_W-1:0]  US_PER_SECOND = 20'd1000000;
    localparam logic [MUL_W-1:0] SEC_PER_MIN   = 32'd60;

    // Speed outputs.
    localparam int SPEED_W = 48;
    localparam int SAT_IN_W = 80;

    // Stream payload widths.
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 152;

    // Event codes on s_tuser; the remaining code only reports the counts.
    localparam logic [S_USER_W-1:0] OP_EDGE_A = 2'd0;
    localparam logic [S_USER_W-1:0] OP_EDGE_B = 2'd1;
    localparam logic [S_USER_W-1:0] OP_TICK   = 2'd2;

    // Register map, indexed by paddr[3:2].
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_EPR    = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_CIRC   = 2'd2;

    localparam logic [15:0] EPR_RESET    = 16'd400;
    localparam logic [23:0] PERIOD_RESET = 24'd10000;
    localparam logic [31:0] CIRC_RESET   = 32'd0;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } qev_div_stat_t;

    // Clamp a magnitude to the signed 48-bit range and apply the sign.
    function automatic logic [SPEED_W-1:0] sat48(input logic [SAT_IN_W-1:0] mag,
                                                 input logic neg);
        logic [SPEED_W-1:0] limit;
        logic [SPEED_W-1:0] m;
        limit = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        m = (mag > SAT_IN_W'(limit)) ? limit : mag[SPEED_W-1:0];
        return neg ? (48'd0 - m) : m;
    endfunction

endpackage

/* sv/quadrature_encoder_velocity.sv */
// ----------------------------------------------------------------------------
// Quadrature encoder velocity
// Counts x4 quadrature edges into a pulse count and a saturating rotation
// count; a velocity tick reports linear speed and rpm in signed Q32.16 and
// clears both counts.
//
// Every request gives one result. An edge request, or one with the unused
// code, is registered as the pending result and handed to the output
// register, which holds it while the next request is taken. A tick request
// works through steps of the single shared 32 by 32 multiplier, the sign
// and magnitude steps, more multiplier steps, the restoring divider, which
// produces one quotient bit per cycle for 64 bits and then flags done, the
// speed and rpm multiplier steps and the hand-off. When the quotient
// overflows 64 bits the divider finishes at once. The hand-off waits while
// the output register is stalled. s_tready is low while a request is being
// worked on, so a new request is taken only after the last is handed off.
// Configuration registers sit at byte addresses 0 (edges per rotation), 4
// (update period in us) and 8 (circumference, Q16.16 mm) and must be written
// while the block is idle.
// ----------------------------------------------------------------------------
`include "quadrature_encoder_velocity_defines.svh"

module quadrature_encoder_velocity #(
    parameter int TURN_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input event channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: [0] level_a, [1] level_b, [7:2] zero
    input  logic [qev_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: [1:0] op
    input  logic [qev_pkg::S_USER_W-1:0]      s_tuser,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: [31:0] rotation_count, [48:32] pulse_count,
    //          [96:49] velocity_q16, [144:97] rpm_q16, [151:145] zero
    output logic [qev_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: [0] speed_valid
    output logic                              m_tuser,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qev_pkg::PADDR_W-1:0]       paddr,
    input  logic [qev_pkg::PDATA_W-1:0]       pwdata,
    output logic [qev_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import qev_pkg::*;

    localparam int DIV_HI_W = US_W + FRAC_BITS;
    localparam int NUM_W    = QUO_W + DIV_HI_W;
    localparam logic signed [TURN_WIDTH-1:0] TURN_MAX = {1'b0, {(TURN_WIDTH-1){1'b1}}};
    localparam logic signed [TURN_WIDTH-1:0] TURN_MIN = {1'b1, {(TURN_WIDTH-1){1'b0}}};
    localparam logic signed [TURN_WIDTH-1:0] TURN_ONE = TURN_WIDTH'(1);

    typedef enum logic [17:0] {
        ST_IDLE = 18'h00001,
        ST_P0   = 18'h00002,
        ST_P1   = 18'h00004,
        ST_P2   = 18'h00008,
        ST_SGN  = 18'h00010,
        ST_ABS  = 18'h00020,
        ST_M0   = 18'h00040,
        ST_M1   = 18'h00080,
        ST_M2   = 18'h00100,
        ST_DST  = 18'h00200,
        ST_DIV  = 18'h00400,
        ST_V0   = 18'h00800,
        ST_V1   = 18'h01000,
        ST_V2   = 18'h02000,
        ST_V3   = 18'h04000,
        ST_V4   = 18'h08000,
        ST_RPM  = 18'h10000,
        ST_EMIT = 18'h20000
    } state_t;

    // Control state
    state_t                        state_reg, state_next;
    logic signed [16:0]            edge_reg, edge_next;
    logic signed [TURN_WIDTH-1:0]  turn_reg, turn_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    // Configuration
    logic [15:0]                   epr_reg;
    logic [23:0]                   period_reg;
    logic [31:0]                   circ_reg;

    // Working registers of a tick
    logic [TURN_WIDTH-1:0]         tmag_reg;
    logic                          tneg_reg;
    logic signed [16:0]            esnap_reg;
    logic [15:0]                   ppr_reg;
    logic [23:0]                   per_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic signed [65:0]            sv_reg;
    logic [63:0]                   mag_reg;
    logic                          neg_reg;
    logic [QUO_W-1:0]              rps_reg;

    // Pending result and output register
    logic [31:0]                   res_rot_reg;
    logic [16:0]                   res_pulse_reg;
    logic                          res_valid_reg;
    logic [SPEED_W-1:0]            res_vel_reg;
    logic [SPEED_W-1:0]            res_rpm_reg;
    logic [M_DATA_W-1:0]           m_tdata_reg;
    logic                          m_tuser_reg;

    // Request decode and edge update
    logic                          in_acc;
    logic [S_USER_W-1:0]           in_op;
    logic                          lvl_a;
    logic                          lvl_b;
    logic                          is_edge;
    logic                          step_down;
    logic signed [17:0]            edge_sum;
    logic [17:0]                   edge_mag;
    logic signed [16:0]            upd_edge;
    logic signed [TURN_WIDTH-1:0]  upd_turn;
    logic signed [63:0]            upd_turn_wide;
    logic                          out_free;
    logic                          cfg_wr;

    // Datapath helpers
    logic [63:0]                   tmag_ext;
    logic signed [65:0]            acc_s;
    logic signed [65:0]            esnap_ext;
    logic signed [65:0]            sv_neg;
    logic [MUL_W-1:0]              mul_a;
    logic [MUL_W-1:0]              mul_b;
    logic [2*MUL_W-1:0]            mul_p;
    logic [NUM_W-1:0]              div_num;
    logic [QUO_W-1:0]              div_quo;
    logic                          div_start;
    qev_div_stat_t                 div_stat;

    assign in_acc   = s_tvalid && s_tready;
    assign in_op    = s_tuser;
    assign lvl_a    = s_tdata[0];
    assign lvl_b    = s_tdata[1];
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Edge step: direction from the phase levels, wrap into the turn count
    // once the magnitude reaches edges per rotation.
    always_comb begin
        upd_edge  = edge_reg;
        upd_turn  = turn_reg;
        is_edge   = (in_op == OP_EDGE_A) || (in_op == OP_EDGE_B);
        step_down = (in_op == OP_EDGE_A) ? (lvl_a == lvl_b) : (lvl_a != lvl_b);
        edge_sum  = step_down ? (18'(edge_reg) - 18'sd1) : (18'(edge_reg) + 18'sd1);
        edge_mag  = edge_sum[17] ? (18'd0 - edge_sum) : edge_sum;
        if (is_edge) begin
            if (edge_mag >= 18'(epr_reg)) begin
                upd_edge = '0;
                if (!edge_sum[17]) begin
                    if (turn_reg != TURN_MAX) begin
                        upd_turn = turn_reg + TURN_ONE;
                    end
                end else if (turn_reg != TURN_MIN) begin
                    upd_turn = turn_reg - TURN_ONE;
                end
            end else begin
                upd_edge = edge_sum[16:0];
            end
        end
    end

    assign upd_turn_wide = 64'(upd_turn);

    // Sequencer and count state
    always_comb begin
        state_next    = state_reg;
        edge_next     = edge_reg;
        turn_next     = turn_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_TICK) begin
                        state_next = ST_P0;
                        edge_next  = '0;
                        turn_next  = '0;
                    end else begin
                        state_next = ST_EMIT;
                        edge_next  = upd_edge;
                        turn_next  = upd_turn;
                    end
                end
            end
            ST_P0:  state_next = ST_P1;
            ST_P1:  state_next = ST_P2;
            ST_P2:  state_next = ST_SGN;
            ST_SGN: state_next = ST_ABS;
            ST_ABS: state_next = ST_M0;
            ST_M0:  state_next = ST_M1;
            ST_M1:  state_next = ST_M2;
            ST_M2:  state_next = ST_DST;
            ST_DST: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_V0;
                end
            end
            ST_V0:  state_next = ST_V1;
            ST_V1:  state_next = ST_V2;
            ST_V2:  state_next = ST_V3;
            ST_V3:  state_next = ST_V4;
            ST_V4:  state_next = ST_RPM;
            ST_RPM: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            edge_reg     <= '0;
            turn_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            epr_reg      <= EPR_RESET;
            period_reg   <= PERIOD_RESET;
            circ_reg     <= CIRC_RESET;
        end else begin
            state_reg    <= state_next;
            edge_reg     <= edge_next;
            turn_reg     <= turn_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_EPR:    epr_reg    <= pwdata[15:0];
                    REG_PERIOD: period_reg <= pwdata[23:0];
                    REG_CIRC:   circ_reg   <= pwdata;
                    default:    ;
                endcase
            end
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            REG_EPR:    prdata = 32'(epr_reg);
            REG_PERIOD: prdata = 32'(period_reg);
            REG_CIRC:   prdata = circ_reg;
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Operand selection for the shared multiplier, one partial product per step.
    assign tmag_ext = 64'(tmag_reg);

    always_comb begin
        case (state_reg)
            ST_P0: begin
                mul_a = tmag_ext[31:0];
                mul_b = 32'(ppr_reg);
            end
            ST_P1: begin
                mul_a = tmag_ext[63:32];
                mul_b = 32'(ppr_reg);
            end
            ST_P2: begin
                mul_a = 32'(ppr_reg);
                mul_b = 32'(per_reg);
            end
            ST_M0: begin
                mul_a = mag_reg[31:0];
                mul_b = 32'(US_PER_SECOND);
            end
            ST_M1: begin
                mul_a = mag_reg[63:32];
                mul_b = 32'(US_PER_SECOND);
            end
            ST_V0: begin
                mul_a = circ_reg;
                mul_b = rps_reg[31:0];
            end
            ST_V1: begin
                mul_a = circ_reg;
                mul_b = rps_reg[63:32];
            end
            ST_V2: begin
                mul_a = rps_reg[31:0];
                mul_b = SEC_PER_MIN;
            end
            ST_V3: begin
                mul_a = rps_reg[63:32];
                mul_b = SEC_PER_MIN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qev_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // Revolutions per second: |num| * 10^6 * 2^FRAC_BITS / (ppr * period).
    assign div_num   = {acc_reg[QUO_W+US_W-1:0], {FRAC_BITS{1'b0}}};
    assign div_start = (state_reg == ST_DST);

    qev_div #(
        .HI_W (DIV_HI_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    assign acc_s     = $signed({2'b00, acc_reg[63:0]});
    assign esnap_ext = 66'(esnap_reg);
    assign sv_neg    = -sv_reg;

    // Datapath registers of the tick calculation and the result hand-off.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_rot_reg   <= upd_turn_wide[31:0];
                    res_pulse_reg <= upd_edge;
                    res_valid_reg <= (in_op == OP_TICK);
                    res_vel_reg   <= '0;
                    res_rpm_reg   <= '0;
                    tneg_reg      <= turn_reg[TURN_WIDTH-1];
                    tmag_reg      <= turn_reg[TURN_WIDTH-1] ? (TURN_WIDTH'(0) - turn_reg)
                                                            : turn_reg;
                    esnap_reg     <= edge_reg;
                    ppr_reg       <= (epr_reg == '0) ? 16'd1 : epr_reg;
                    per_reg       <= (period_reg == '0) ? 24'd1 : period_reg;
                end
            end
            // Turn count magnitude times edges per rotation.
            ST_P1:  acc_reg <= ACC_W'(mul_p);
            ST_P2:  acc_reg <= acc_reg + (ACC_W'(mul_p) << 32);
            // Signed position in edges, and the divisor.
            ST_SGN: begin
                den_reg <= mul_p[DEN_W-1:0];
                sv_reg  <= tneg_reg ? (esnap_ext - acc_s) : (acc_s + esnap_ext);
            end
            ST_ABS: begin
                neg_reg <= sv_reg[65];
                mag_reg <= sv_reg[65] ? sv_neg[63:0] : sv_reg[63:0];
            end
            // Scale to microseconds.
            ST_M1:  acc_reg <= ACC_W'(mul_p);
            ST_M2:  acc_reg <= acc_reg + (ACC_W'(mul_p) << 32);
            ST_DIV: begin
                if (div_stat.done) begin
                    rps_reg <= div_quo;
                end
            end
            // Linear speed: circumference times rps, Q16.16 circumference.
            ST_V1:  acc_reg <= ACC_W'(mul_p);
            ST_V2:  acc_reg <= acc_reg + (ACC_W'(mul_p) << 32);
            ST_V3: begin
                res_vel_reg <= sat48(acc_reg[ACC_W-1:16], neg_reg);
                acc_reg     <= ACC_W'(mul_p);
            end
            // Rpm: rps times sixty.
            ST_V4:  acc_reg <= acc_reg + (ACC_W'(mul_p) << 32);
            ST_RPM: res_rpm_reg <= sat48(SAT_IN_W'(acc_reg[69:0]), neg_reg);
            ST_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {7'b0, res_rpm_reg, res_vel_reg, res_pulse_reg, res_rot_reg};
                    m_tuser_reg <= res_valid_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `QEV_ASSERT_NEXT(a_tick_clears, in_acc && in_op == OP_TICK,
        edge_reg == '0 && turn_reg == '0, "tick did not clear the counts")
    `QEV_ASSERT(a_edge_zero_speed, m_tvalid_reg && !m_tuser_reg,
        m_tdata_reg[144:49] == '0, "speed reported without a tick")
    `QEV_ASSERT(a_emit_source, $rose(m_tvalid_reg), $past(state_reg == ST_EMIT),
        "result presented outside the emit step")
    `QEV_ASSERT_NEXT(a_div_handoff, state_reg == ST_DIV && div_stat.done,
        state_reg == ST_V0, "quotient not taken on divider done")
    `QEV_ASSERT(a_div_wait, state_reg == ST_DIV, div_stat.busy || div_stat.done,
        "waiting on an idle divider")

endmodule

/* sv/qev_mul.sv */
// ----------------------------------------------------------------------------
// Quadrature encoder velocity: shared multiplier
// Unsigned 32 by 32 bit multiplier with a registered product, reused for
// every partial product of the velocity calculation.
// ----------------------------------------------------------------------------
module qev_mul (
    input  logic                          aclk,
    input  logic [qev_pkg::MUL_W-1:0]     a,
    input  logic [qev_pkg::MUL_W-1:0]     b,
    output logic [2*qev_pkg::MUL_W-1:0]   p
);
    import qev_pkg::*;

    logic [2*MUL_W-1:0] p_reg;

    // Product is registered and available in the cycle after the operands.
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* sv/qev_div.sv */
// ----------------------------------------------------------------------------
// Quadrature encoder velocity: restoring divider
// Divides a wide numerator by a 40-bit denominator, one quotient bit per
// cycle, and saturates the quotient to 64 bits.
// ----------------------------------------------------------------------------
`include "quadrature_encoder_velocity_defines.svh"

module qev_div #(
    parameter int HI_W = 36
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [HI_W+qev_pkg::QUO_W-1:0]      num,
    input  logic [qev_pkg::DEN_W-1:0]           den,
    output logic [qev_pkg::QUO_W-1:0]           quo,
    output qev_pkg::qev_div_stat_t              stat
);
    import qev_pkg::*;

    localparam int CMP_W = (HI_W > DEN_W + 1) ? HI_W : DEN_W + 1;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_cmp;
    logic             sat;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // The upper numerator part decides saturation: if it is not below the
    // denominator the quotient cannot fit in 64 bits.
    assign hi_ext  = CMP_W'(num[HI_W+QUO_W-1:QUO_W]);
    assign den_cmp = CMP_W'(den);
    assign sat     = hi_ext >= den_cmp;

    // One restoring step: bring in the next numerator bit and try a subtract.
    assign trial = {rem_reg[DEN_W-1:0], quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = trial >= {1'b0, den};

    // Control: busy over the 64 steps, done for one cycle at the end; a saturating start skips the steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            if (sat) begin
                quo_reg <= '1;
            end else begin
                rem_reg <= hi_ext[DEN_W:0];
                quo_reg <= num[QUO_W-1:0];
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? diff : trial;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `QEV_ASSERT(a_div_start_idle, start, !busy_reg, "divider started while busy")
    `QEV_ASSERT_NEXT(a_div_done_pulse, done_reg, !done_reg, "divider done held too long")
    `QEV_ASSERT(a_div_done_not_busy, done_reg, !busy_reg, "divider done while still busy")
    `QEV_ASSERT_NEXT(a_div_keeps_busy, busy_reg && cnt_reg != CNT_LAST, busy_reg,
        "divider stopped early")

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Quadrature encoder velocity testbench
// Drives encoder edge, velocity tick and unused-code requests through the
// event stream under several register settings. A local predictor tracks the
// edge and turn counts and computes the expected counts and speeds of every
// result. Results are checked field by field in order, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import qev_pkg::*;

    // The unused code only reports the counts.
    localparam logic [1:0] OP_REPORT = 2'd3;
    localparam int FRAC = 16;
    localparam logic signed [31:0] TURN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TURN_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0] op;
        logic       a;
        logic       b;
    } enc_event_t;

    typedef struct packed {
        logic [31:0] turns;
        logic [16:0] pulses;
        logic        speed;
        logic [47:0] vel;
        logic [47:0] rpm;
    } reading_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [S_USER_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    quadrature_encoder_velocity uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Predictor state and its copy of the registers.
    logic signed [16:0] edge_cnt   = '0;
    logic signed [31:0] turn_cnt   = '0;
    logic [15:0]        epr_cfg    = EPR_RESET;
    logic [23:0]        period_cfg = PERIOD_RESET;
    logic [31:0]        circ_cfg   = CIRC_RESET;

    enc_event_t event_q[$];
    reading_t   reading_q[$];
    int         err_count = 0;
    bit         req_taken = 1'b0;

    // Sender burst state, receiver stall state, and the encoder walk.
    int         burst_left = 0;
    int         gap_left   = 0;
    int         stall_mode = 0;
    int         stall_left = 0;
    int unsigned stall_cyc = 0;
    logic       a_walk = 1'b0;
    logic       b_walk = 1'b0;
    logic       walk_up = 1'b1;
    int         run_left = 0;
    int         tick_left = 10;

    enc_event_t drv_ev;
    reading_t   got, want;

    // Clamp a magnitude to the signed 48-bit range and apply the sign.
    function automatic logic [47:0] clamp48(input logic [127:0] m, input logic neg);
        logic [127:0] limit;
        limit = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
        if (m > limit)
            m = limit;
        return neg ? (48'd0 - m[47:0]) : m[47:0];
    endfunction

    // Update the counts for one request and return the result it causes.
    function automatic reading_t predict_reading(input logic [1:0] op, input logic a,
                                                 input logic b);
        reading_t     r;
        int           delta, e, mag;
        longint       num, absn;
        logic         neg;
        logic [63:0]  ppr, per, rps;
        logic [127:0] den, quo, velw, rpmw;
        r = '0;
        delta = 0;
        if (op == OP_EDGE_A)
            delta = (a == b) ? -1 : 1;
        else if (op == OP_EDGE_B)
            delta = (a != b) ? -1 : 1;
        // A full revolution moves the turn count by the sign of the edge count.
        if (delta != 0) begin
            e = int'(edge_cnt) + delta;
            mag = (e < 0) ? -e : e;
            if (mag >= int'(epr_cfg)) begin
                if (e >= 0 && turn_cnt != TURN_MAX)
                    turn_cnt = turn_cnt + 32'sd1;
                else if (e < 0 && turn_cnt != TURN_MIN)
                    turn_cnt = turn_cnt - 32'sd1;
                edge_cnt = '0;
            end else begin
                edge_cnt = e[16:0];
            end
        end
        r.turns  = turn_cnt;
        r.pulses = edge_cnt;
        // A tick reports the speeds from the counts, then clears them.
        if (op == OP_TICK) begin
            ppr  = (epr_cfg == '0) ? 64'd1 : 64'(epr_cfg);
            per  = (period_cfg == '0) ? 64'd1 : 64'(period_cfg);
            num  = longint'(turn_cnt) * longint'(ppr) + longint'(edge_cnt);
            neg  = (num < 0);
            absn = neg ? -num : num;
            den  = 128'(ppr) * 128'(per);
            quo  = (({64'd0, absn} * 128'(US_PER_SECOND)) << FRAC) / den;
            rps  = (quo[127:64] != '0) ? '1 : quo[63:0];
            velw = (128'(circ_cfg) * 128'(rps)) >> 16;
            rpmw = 128'(rps) * 128'(SEC_PER_MIN);
            r.speed  = 1'b1;
            r.vel    = clamp48(velw, neg);
            r.rpm    = clamp48(rpmw, neg);
            edge_cnt = '0;
            turn_cnt = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (event_q.size() > 0) begin
                drv_ev = event_q.pop_front();
                s_tuser  <= drv_ev.op;
                s_tdata  <= {6'd0, drv_ev.b, drv_ev.a};
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Result receiver: the stall pattern switches between a few modes.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        stall_cyc++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_cyc % 4 == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Monitor: check each result against the oldest expectation, then
    // predict the result of a request taken at this edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.turns  = m_tdata[31:0];
                got.pulses = m_tdata[48:32];
                got.vel    = m_tdata[96:49];
                got.rpm    = m_tdata[144:97];
                got.speed  = m_tuser;
                if (reading_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time,
                             m_tdata);
                    err_count++;
                end else begin
                    want = reading_q.pop_front();
                    check_field("rotation_count", 64'(want.turns), 64'(got.turns));
                    check_field("pulse_count", 64'(want.pulses), 64'(got.pulses));
                    check_field("speed_valid", 64'(want.speed), 64'(got.speed));
                    check_field("velocity_q16", 64'(want.vel), 64'(got.vel));
                    check_field("rpm_q16", 64'(want.rpm), 64'(got.rpm));
                end
            end
            if (s_tvalid && s_tready) begin
                req_taken = 1'b1;
                reading_q.push_back(predict_reading(s_tuser, s_tdata[0], s_tdata[1]));
            end
        end
    end

    task automatic push_event(input logic [1:0] op, input logic a, input logic b);
        enc_event_t ev;
        ev.op = op;
        ev.a  = a;
        ev.b  = b;
        event_q.push_back(ev);
    endtask

    // Wait until every request is taken and every result has arrived, then
    // return at a falling edge.
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (!(event_q.size() == 0 && !s_tvalid && reading_q.size() == 0));
        @(negedge aclk);
    endtask

    // Write all three registers through the configuration port.
    task automatic configure(input logic [15:0] epr, input logic [23:0] per,
                             input logic [31:0] circ);
        logic [31:0] vals[3];
        logic [1:0]  regs[3];
        vals = '{32'(epr), 32'(per), circ};
        regs = '{REG_EPR, REG_PERIOD, REG_CIRC};
        for (int i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[i], 2'b00};
            pwdata  <= vals[i];
            @(negedge aclk);
            penable <= 1'b1;
            @(negedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        epr_cfg    = epr;
        period_cfg = per;
        circ_cfg   = circ;
    endtask

    // Mostly clean quadrature walks in runs of either direction, with noise
    // edges, unused codes and ticks mixed in.
    task automatic gen_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (tick_left == 0) begin
                push_event(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                tick_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(2, 40);
            end else begin
                tick_left--;
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    push_event(OP_REPORT, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end else if (r < 12) begin
                    a_walk = 1'($urandom_range(0, 1));
                    b_walk = 1'($urandom_range(0, 1));
                    push_event(($urandom_range(0, 1) != 0) ? OP_EDGE_B : OP_EDGE_A,
                               a_walk, b_walk);
                end else begin
                    if (run_left == 0) begin
                        walk_up  = 1'($urandom_range(0, 1));
                        run_left = $urandom_range(1, 150);
                    end
                    run_left--;
                    // Forward steps toggle A when the phases agree, else B.
                    if ((a_walk == b_walk) == walk_up) begin
                        a_walk = ~a_walk;
                        push_event(OP_EDGE_A, a_walk, b_walk);
                    end else begin
                        b_walk = ~b_walk;
                        push_event(OP_EDGE_B, a_walk, b_walk);
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: every edge direction and level pair, unused code, tick.
        for (int i = 0; i < 4; i++)
            push_event(OP_EDGE_A, i[1], i[0]);
        for (int i = 0; i < 4; i++)
            push_event(OP_EDGE_B, i[1], i[0]);
        push_event(OP_REPORT, 1'b1, 1'b0);
        push_event(OP_TICK, 1'b0, 1'b0);
        wait_idle();

        // One edge per turn, shortest period, widest drum: the linear speed
        // saturates in both directions.
        configure(16'd1, 24'd1, 32'hFFFF_FFFF);
        push_event(OP_EDGE_A, 1'b1, 1'b0);
        push_event(OP_EDGE_B, 1'b1, 1'b1);
        push_event(OP_EDGE_A, 1'b0, 1'b1);
        push_event(OP_TICK, 1'b1, 1'b1);
        push_event(OP_EDGE_A, 1'b0, 1'b0);
        push_event(OP_EDGE_B, 1'b0, 1'b1);
        push_event(OP_TICK, 1'b0, 1'b0);
        wait_idle();

        // Zero edges per rotation and zero period fall back to one.
        configure(16'd0, 24'd0, 32'h0001_0000);
        push_event(OP_EDGE_A, 1'b1, 1'b1);
        push_event(OP_EDGE_B, 1'b0, 1'b0);
        push_event(OP_EDGE_A, 1'b1, 1'b0);
        push_event(OP_TICK, 1'b0, 1'b1);
        wait_idle();

        // Random phases under a spread of register settings.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
                1: configure(16'd1, 24'd1, $urandom);
                2: configure(16'd4, 24'($urandom_range(1, 1000)), $urandom);
                3: configure(16'($urandom_range(2, 32)),
                             24'($urandom_range(1, 24'hFF_FFFF)),
                             $urandom_range(0, 1000) << 16);
                4: configure(16'($urandom_range(1, 400)), 24'($urandom_range(1, 20000)),
                             $urandom);
                default: configure(16'($urandom_range(1, 16'hFFFF)),
                                   24'($urandom_range(1, 100)), $urandom);
            endcase
            gen_random(260);
            wait_idle();
        end

        repeat (100) @(posedge aclk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
